### rtl/dlt_pkg.sv
// Package for the DOT language tokenizer: result record, token codes and
// keyword tables. No dependencies.
`default_nettype none
package dlt_pkg;

  localparam int POSITION_BITS_DEF   = 16;
  localparam int HTML_DEPTH_BITS_DEF = 8;
  localparam int MAX_RESULTS         = 3;
  localparam int NUM_KEYWORDS        = 6;

  // Kind of a result item.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Token types.
  localparam logic [4:0] T_EDGE     = 5'd9;
  localparam logic [4:0] T_STRING   = 5'd10;
  localparam logic [4:0] T_HTML     = 5'd11;
  localparam logic [4:0] T_ID       = 5'd12;
  localparam logic [4:0] T_KEYWORD0 = 5'd13;
  localparam logic [4:0] T_EOF      = 5'd19;

  // Error codes.
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;
  localparam logic [1:0] ERR_HTML   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value_byte;
    logic [4:0]  token_type;
    logic [1:0]  error_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last;
  } res_t;

  // Keyword text, right justified, first character in the highest used byte.
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] =
    '{64'("strict"), 64'("graph"), 64'("digraph"), 64'("node"), 64'("edge"),
      64'("subgraph")};
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] =
    '{4'd6, 4'd5, 4'd7, 4'd4, 4'd4, 4'd8};

  function automatic logic kw_hit(input int k, input logic [3:0] idx, input logic [7:0] b);
    logic [2:0] sh;
    logic [3:0] diff;
    kw_hit = 1'b0;
    diff = KW_LEN[k] - 4'd1 - idx;
    sh = diff[2:0];
    if (idx < KW_LEN[k]) begin
      kw_hit = (KW_TEXT[k][{sh, 3'b000} +: 8] == b);
    end
  endfunction

  // Drops the keywords that no longer match after byte b at position idx.
  function automatic logic [5:0] kw_track(input logic [5:0] mask, input logic [3:0] idx,
                                          input logic [7:0] b);
    kw_track = mask;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (!kw_hit(k, idx, b)) kw_track[k] = 1'b0;
    end
  endfunction

  function automatic logic [4:0] ident_type(input logic [5:0] mask, input logic [3:0] len);
    ident_type = T_ID;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (mask[k] && KW_LEN[k] == len) ident_type = T_KEYWORD0 + 5'(k);
    end
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    is_numeral = (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b);
    mk_byte = '0;
    mk_byte.kind = KIND_BYTE;
    mk_byte.value_byte = b;
  endfunction

  function automatic res_t mk_rec(input logic [1:0] kind, input logic [4:0] tt,
                                  input logic [1:0] ec, input logic [15:0] l,
                                  input logic [15:0] c);
    mk_rec = '0;
    mk_rec.kind = kind;
    mk_rec.token_type = tt;
    mk_rec.error_code = ec;
    mk_rec.start_line = l;
    mk_rec.start_column = c;
  endfunction

endpackage
`default_nettype wire

### rtl/dlt_out_buf.sv
// Result buffer of the DOT tokenizer: holds up to three results of one input
// item, handed out one per cycle while ready_i is high. Depends on dlt_pkg.
`default_nettype none
module dlt_out_buf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire  [1:0]           count_i,
  input  dlt_pkg::res_t [2:0]  res_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire                  ready_i,
  output dlt_pkg::res_t        res_o
);

  dlt_pkg::res_t [2:0] slot_q, slot_d;
  logic [1:0] cnt_q, cnt_d;
  logic pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = slot_q[0];
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d = cnt_q - 2'd1;
    end
    if (load_i) begin
      slot_d = res_i;
      cnt_d  = count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
`default_nettype wire

### rtl/dot_language_tokenizer_unit.sv
// Top level of the DOT language tokenizer: lexer state, per-byte decoding
// and the result buffer. Depends on dlt_pkg and dlt_out_buf.
//
// The tokenizer takes one text byte (or an end-of-text mark) per cycle while
// its result buffer has room, and turns it into zero to three result items:
// value bytes, token end records with type and start position, and error
// records. Each input item is decoded combinationally from the lexer state
// registers into a three-slot result buffer, which then drains one item per
// cycle while the downstream side is ready. A new input item is taken when
// the buffer is empty or its one waiting result is taken in the same cycle,
// so input slows where an item yields several results or downstream stalls.
`default_nettype none
module dot_language_tokenizer_unit #(
  parameter int POSITION_BITS   = dlt_pkg::POSITION_BITS_DEF,
  parameter int HTML_DEPTH_BITS = dlt_pkg::HTML_DEPTH_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // in_byte
  input  wire         s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // value_byte, token_type, error_code,
                                      // start_line, start_column, zero pad
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_of_item
);

  localparam logic [4:0] M_IDLE = 5'd0,  M_MINUS = 5'd1,  M_DOT = 5'd2,
                         M_SLASH = 5'd3, M_LINE_CMT = 5'd4, M_BLOCK_CMT = 5'd5,
                         M_BLOCK_STAR = 5'd6, M_STRING = 5'd7, M_ESCAPE = 5'd8,
                         M_HTML = 5'd9, M_IDENT = 5'd10, M_NUM_INT = 5'd11,
                         M_NUM_FRAC = 5'd12, M_NUM_EXP_SIGN = 5'd13,
                         M_NUM_EXP = 5'd14, M_ERROR = 5'd15;

  localparam logic [POSITION_BITS-1:0]   POS_ONE   = POSITION_BITS'(1);
  localparam logic [HTML_DEPTH_BITS-1:0] DEPTH_ONE = HTML_DEPTH_BITS'(1);

  logic [4:0]                 mode_q, mode_d;
  logic [5:0]                 mask_q, mask_d;
  logic [3:0]                 idlen_q, idlen_d;
  logic [HTML_DEPTH_BITS-1:0] depth_q, depth_d;
  logic [POSITION_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0]   sline_q, sline_d, scol_q, scol_d;

  dlt_pkg::res_t [2:0] res;
  logic [1:0] n;
  logic accept, room, do_start;
  logic [7:0] b;
  logic [POSITION_BITS+15:0] ext_line, ext_col, ext_sline, ext_scol;
  logic [15:0] line16, col16, sline16, scol16;
  dlt_pkg::res_t out_res;

  assign b = s_axis_tdata;
  assign s_axis_tready = room;
  assign accept = s_axis_tvalid && room;

  assign ext_line  = {16'b0, line_q};
  assign ext_col   = {16'b0, col_q};
  assign ext_sline = {16'b0, sline_q};
  assign ext_scol  = {16'b0, scol_q};
  assign line16  = ext_line[15:0];
  assign col16   = ext_col[15:0];
  assign sline16 = ext_sline[15:0];
  assign scol16  = ext_scol[15:0];

  always_comb begin
    mode_d  = mode_q;
    mask_d  = mask_q;
    idlen_d = idlen_q;
    depth_d = depth_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    res      = '0;
    n        = 2'd0;
    do_start = 1'b0;

    if (s_axis_tuser) begin
      // End of text: flush the open token, then EOF unless an error stands or arises.
      unique case (mode_q)
        M_ERROR: ;
        M_MINUS, M_DOT, M_SLASH: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_CHAR, sline16, scol16);
          n = n + 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_STRING, sline16, scol16);
          n = n + 2'd1;
        end
        M_HTML: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_HTML, sline16, scol16);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::ident_type(mask_q, idlen_q),
                                   2'd0, sline16, scol16);
          n = n + 2'd1;
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_EOF, 2'd0, line16, col16);
          n = n + 2'd1;
        end
        M_NUM_INT, M_NUM_FRAC, M_NUM_EXP_SIGN, M_NUM_EXP: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_ID, 2'd0, sline16, scol16);
          n = n + 2'd1;
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_EOF, 2'd0, line16, col16);
          n = n + 2'd1;
        end
        default: begin
          res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_EOF, 2'd0, line16, col16);
          n = n + 2'd1;
        end
      endcase
      mode_d  = M_IDLE;
      depth_d = '0;
      line_d  = POS_ONE;
      col_d   = POS_ONE;
    end else begin
      unique case (mode_q)
        M_ERROR: ;
        M_MINUS: begin
          if (b == ">" || b == "-") begin
            res[n] = dlt_pkg::mk_byte("-");
            n = n + 2'd1;
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_EDGE, 2'd0, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_CHAR, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_ERROR;
          end
        end
        M_DOT: begin
          if (dlt_pkg::is_numeral(b)) begin
            res[n] = dlt_pkg::mk_byte(".");
            n = n + 2'd1;
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            mode_d = M_NUM_FRAC;
          end else begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_CHAR, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_ERROR;
          end
        end
        M_SLASH: begin
          if (b == "/") begin
            mode_d = M_LINE_CMT;
          end else if (b == "*") begin
            mode_d = M_BLOCK_CMT;
          end else begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_CHAR, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_ERROR;
          end
        end
        M_LINE_CMT: begin
          if (b == 8'h0A) mode_d = M_IDLE;
        end
        M_BLOCK_CMT: begin
          if (b == "*") mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (b == "/") mode_d = M_IDLE;
          else if (b != "*") mode_d = M_BLOCK_CMT;
        end
        M_STRING: begin
          if (b == "\"") begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_STRING, 2'd0, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else if (b == "\\") begin
            mode_d = M_ESCAPE;
          end else begin
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
          end
        end
        M_ESCAPE: begin
          if (b == "n")      res[n] = dlt_pkg::mk_byte(8'h0A);
          else if (b == "t") res[n] = dlt_pkg::mk_byte(8'h09);
          else if (b == "r") res[n] = dlt_pkg::mk_byte(8'h0D);
          else               res[n] = dlt_pkg::mk_byte(b);
          n = n + 2'd1;
          mode_d = M_STRING;
        end
        M_HTML: begin
          if (b == "<") begin
            if (depth_q != '1) depth_d = depth_q + DEPTH_ONE;
          end else if (b == ">") begin
            if (depth_q != '0) depth_d = depth_q - DEPTH_ONE;
          end
          res[n] = dlt_pkg::mk_byte(b);
          n = n + 2'd1;
          if (depth_d == '0) begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_HTML, 2'd0, sline16, scol16);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_IDENT: begin
          if (dlt_pkg::is_letter(b) || dlt_pkg::is_numeral(b)) begin
            mask_d = dlt_pkg::kw_track(mask_q, idlen_q, b);
            if (idlen_q != 4'd15) idlen_d = idlen_q + 4'd1;
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
          end else begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::ident_type(mask_q, idlen_q),
                                     2'd0, sline16, scol16);
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_NUM_INT, M_NUM_FRAC, M_NUM_EXP_SIGN, M_NUM_EXP: begin
          if (dlt_pkg::is_numeral(b)) begin
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            if (mode_q == M_NUM_EXP_SIGN) mode_d = M_NUM_EXP;
          end else if (b == "." && mode_q == M_NUM_INT) begin
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            mode_d = M_NUM_FRAC;
          end else if ((b == "e" || b == "E") && (mode_q == M_NUM_INT || mode_q == M_NUM_FRAC))
          begin
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            mode_d = M_NUM_EXP_SIGN;
          end else if ((b == "+" || b == "-") && mode_q == M_NUM_EXP_SIGN) begin
            res[n] = dlt_pkg::mk_byte(b);
            n = n + 2'd1;
            mode_d = M_NUM_EXP;
          end else begin
            res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, dlt_pkg::T_ID, 2'd0, sline16, scol16);
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      // Start of a new token from the idle state; a token closed by this
      // byte falls through to here as well.
      if (do_start) begin
        mode_d = M_IDLE;
        if (!dlt_pkg::is_space(b)) begin
          sline_d = line_q;
          scol_d  = col_q;
          priority case (1'b1)
            (b == "[" || b == "]" || b == "{" || b == "}" || b == "," || b == ":" ||
             b == ";" || b == "=" || b == "+"): begin
              res[n] = dlt_pkg::mk_byte(b);
              n = n + 2'd1;
              unique case (b)
                "[":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd0, 2'd0, line16, col16);
                "]":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd1, 2'd0, line16, col16);
                "{":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd2, 2'd0, line16, col16);
                "}":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd3, 2'd0, line16, col16);
                ",":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd4, 2'd0, line16, col16);
                ":":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd5, 2'd0, line16, col16);
                ";":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd6, 2'd0, line16, col16);
                "=":     res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd7, 2'd0, line16, col16);
                default: res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_END, 5'd8, 2'd0, line16, col16);
              endcase
              n = n + 2'd1;
            end
            (b == "-"): mode_d = M_MINUS;
            (b == "\""): mode_d = M_STRING;
            (b == "<"): begin
              depth_d = DEPTH_ONE;
              res[n] = dlt_pkg::mk_byte(b);
              n = n + 2'd1;
              mode_d = M_HTML;
            end
            dlt_pkg::is_numeral(b): begin
              res[n] = dlt_pkg::mk_byte(b);
              n = n + 2'd1;
              mode_d = M_NUM_INT;
            end
            (b == "."): mode_d = M_DOT;
            dlt_pkg::is_letter(b): begin
              mask_d  = dlt_pkg::kw_track(6'h3F, 4'd0, b);
              idlen_d = 4'd1;
              res[n] = dlt_pkg::mk_byte(b);
              n = n + 2'd1;
              mode_d = M_IDENT;
            end
            (b == "/"): mode_d = M_SLASH;
            (b == "#"): mode_d = M_LINE_CMT;
            default: begin
              res[n] = dlt_pkg::mk_rec(dlt_pkg::KIND_ERR, 5'd0, dlt_pkg::ERR_CHAR, line16, col16);
              n = n + 2'd1;
              mode_d = M_ERROR;
            end
          endcase
        end
      end

      if (mode_d != M_ERROR) begin
        if (b == 8'h0A) begin
          if (line_q != '1) line_d = line_q + POS_ONE;
          col_d = POS_ONE;
        end else if (col_q != '1) begin
          col_d = col_q + POS_ONE;
        end
      end
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      mask_q  <= 6'h3F;
      idlen_q <= 4'd0;
      depth_q <= '0;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      sline_q <= POS_ONE;
      scol_q  <= POS_ONE;
    end else if (accept) begin
      mode_q  <= mode_d;
      mask_q  <= mask_d;
      idlen_q <= idlen_d;
      depth_q <= depth_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

  dlt_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .count_i (n),
    .res_i   (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.start_column, out_res.start_line, out_res.error_code,
                         out_res.token_type, out_res.value_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire
